// ===== hdl/epaper_update_request_policy_assert.svh =====
// Assertion helpers used by the checker file of the update request policy.
`ifndef EPAPER_UPDATE_REQUEST_POLICY_ASSERT_SVH
`define EPAPER_UPDATE_REQUEST_POLICY_ASSERT_SVH

// Same-cycle implication, muted while reset is asserted.
`define EURP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("eurp assertion failed");

// Next-cycle implication, muted while reset is asserted.
`define EURP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("eurp assertion failed");

// Next-cycle implication that also runs during reset.
`define EURP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("eurp assertion failed");

`endif

// ===== hdl/eurp_pkg.sv =====
package eurp_pkg;

    localparam int DEF_PANEL_WIDTH  = 1648;
    localparam int DEF_PANEL_HEIGHT = 824;
    localparam int DEF_MAX_RECTS    = 8;

    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 4;
    localparam int COORD_W    = 16;
    localparam int WAVE_W     = 4;
    localparam int MODE_W     = 2;
    localparam int MS_W       = 16;
    localparam int MARKER_W   = 32;
    localparam int FLAG_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Input payload: 32 + 3 flags + 4 + 4 * 16 = 103 bits, padded to bytes.
    localparam int IN_BITS    = TIME_W + 3 + COUNT_W + 4 * COORD_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Update mode used when a periodic full flash is forced.
    localparam logic [MODE_W-1:0] MODE_FULL_FLASH = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE       = 3'd0,
        CFG_QUALITY_WF   = 3'd1,
        CFG_NORMAL_MODE  = 3'd2,
        CFG_FAST_WF      = 3'd3,
        CFG_MOTION_MS    = 3'd4,
        CFG_FULL_EVERY   = 3'd5,
        CFG_MIN_INTERVAL = 3'd6,
        CFG_FLAG_WORD    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                    enable;
        logic [WAVE_W-1:0]       quality_waveform;
        logic [MODE_W-1:0]       normal_mode;
        logic [WAVE_W-1:0]       fast_waveform;
        logic [MS_W-1:0]         motion_window_ms;
        logic [MS_W-1:0]         full_every;
        logic [MS_W-1:0]         min_interval_ms;
        logic [FLAG_W-1:0]       driver_flag_word;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]        time_ms;
        logic                     test_only;
        logic                     frame_changed;
        logic                     full_request;
        logic [COUNT_W-1:0]       rect_count;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic                     last;
    } in_item_t;

    // Per-item decision handed from the commit tracker to the result stage.
    typedef struct packed {
        logic                  emit;
        logic                  full;
        logic                  last;
        logic [WAVE_W-1:0]     waveform;
        logic [MODE_W-1:0]     mode;
        logic [MARKER_W-1:0]   marker;
    } desc_info_t;

endpackage

// ===== hdl/eurp_cfg_regs.sv =====
module eurp_cfg_regs import eurp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:       cfg_next.enable             = cfg_data[0];
                CFG_QUALITY_WF:   cfg_next.quality_waveform   = cfg_data[WAVE_W-1:0];
                CFG_NORMAL_MODE:  cfg_next.normal_mode        = cfg_data[MODE_W-1:0];
                CFG_FAST_WF:      cfg_next.fast_waveform      = cfg_data[WAVE_W-1:0];
                CFG_MOTION_MS:    cfg_next.motion_window_ms   = cfg_data[MS_W-1:0];
                CFG_FULL_EVERY:   cfg_next.full_every         = cfg_data[MS_W-1:0];
                CFG_MIN_INTERVAL: cfg_next.min_interval_ms    = cfg_data[MS_W-1:0];
                CFG_FLAG_WORD:    cfg_next.driver_flag_word   = cfg_data[FLAG_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable             <= 1'b1;
            cfg_reg.quality_waveform   <= 4'd2;
            cfg_reg.normal_mode        <= 2'd1;
            cfg_reg.fast_waveform      <= 4'd0;
            cfg_reg.motion_window_ms   <= 16'd250;
            cfg_reg.full_every         <= 16'd0;
            cfg_reg.min_interval_ms    <= 16'd0;
            cfg_reg.driver_flag_word   <= 32'h0002_1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/eurp_commit_ctrl.sv =====
module eurp_commit_ctrl import eurp_pkg::*; #(
    parameter int MAX_RECTS = DEF_MAX_RECTS,
    localparam int RW = $clog2(MAX_RECTS + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    input  in_item_t      item,
    input  logic          advance,
    output desc_info_t    info,
    output logic [RW-1:0] rect_total
);

    localparam int CW = (RW > COUNT_W) ? RW : COUNT_W;
    localparam logic [RW-1:0] MAX_R = RW'(MAX_RECTS);

    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic                have_reg, have_next;
    logic [MS_W-1:0]     usf_reg, usf_next;
    logic [MARKER_W-1:0] marker_reg, marker_next;
    logic                mid_reg, mid_next;
    logic                emits_reg, emits_next;
    logic                full_reg, full_next;
    logic [WAVE_W-1:0]   wf_reg, wf_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [RW-1:0]       total_reg, total_next;
    logic [RW-1:0]       index_reg, index_next;

    logic [TIME_W-1:0]   dt;
    logic                fire;
    logic                motion;
    logic [MS_W-1:0]     usf_inc;
    logic                flash_due;
    logic                start_full;
    logic [CW-1:0]       cnt_ext;
    logic [CW-1:0]       cnt_clamped;
    logic                cur_emits;
    logic                cur_full;
    logic [WAVE_W-1:0]   cur_wf;
    logic [MODE_W-1:0]   cur_mode;
    logic [RW-1:0]       cur_total;
    logic [RW-1:0]       cur_index;
    logic [MARKER_W-1:0] cur_marker;

    always_comb begin
        dt      = item.time_ms - last_time_reg;
        fire    = !item.test_only && cfg.enable && item.frame_changed
                  && !(cfg.min_interval_ms != '0 && have_reg
                       && dt < TIME_W'(cfg.min_interval_ms));
        motion  = cfg.fast_waveform != '0 && have_reg
                  && dt < TIME_W'(cfg.motion_window_ms);
        usf_inc = usf_reg + MS_W'(1);
        flash_due   = cfg.full_every != '0 && usf_inc >= cfg.full_every;
        start_full  = item.full_request || flash_due || item.rect_count == '0;
        cnt_ext     = CW'(item.rect_count);
        cnt_clamped = (cnt_ext > CW'(MAX_RECTS)) ? CW'(MAX_RECTS) : cnt_ext;

        // The first item of a commit decides; later items reuse the stored decision.
        if (!mid_reg) begin
            cur_emits  = fire;
            cur_full   = start_full;
            cur_wf     = (flash_due || !motion) ? cfg.quality_waveform : cfg.fast_waveform;
            cur_mode   = flash_due ? MODE_FULL_FLASH : cfg.normal_mode;
            cur_total  = !fire ? '0 : (start_full ? RW'(1) : cnt_clamped[RW-1:0]);
            cur_index  = '0;
            cur_marker = marker_reg + MARKER_W'(fire);
        end else begin
            cur_emits  = emits_reg;
            cur_full   = full_reg;
            cur_wf     = wf_reg;
            cur_mode   = mode_reg;
            cur_total  = total_reg;
            cur_index  = index_reg;
            cur_marker = marker_reg;
        end

        info.emit     = cur_emits && cur_index < cur_total;
        info.full     = cur_full;
        info.last     = ((RW+1)'(cur_index) + (RW+1)'(1)) == (RW+1)'(cur_total);
        info.waveform = cur_wf;
        info.mode     = cur_mode;
        info.marker   = cur_marker;
        rect_total    = cur_total;

        last_time_next = last_time_reg;
        have_next      = have_reg;
        usf_next       = usf_reg;
        marker_next    = marker_reg;
        mid_next       = mid_reg;
        emits_next     = emits_reg;
        full_next      = full_reg;
        wf_next        = wf_reg;
        mode_next      = mode_reg;
        total_next     = total_reg;
        index_next     = index_reg;

        if (advance) begin
            if (!mid_reg && fire) begin
                last_time_next = item.time_ms;
                have_next      = 1'b1;
                marker_next    = cur_marker;
                if (cfg.full_every != '0) begin
                    usf_next = flash_due ? '0 : usf_inc;
                end
            end
            emits_next = cur_emits;
            full_next  = cur_full;
            wf_next    = cur_wf;
            mode_next  = cur_mode;
            total_next = cur_total;
            mid_next   = !item.last;
            if (item.last) begin
                index_next = '0;
            end else if (cur_index != MAX_R) begin
                index_next = cur_index + RW'(1);
            end else begin
                index_next = cur_index;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            have_reg      <= 1'b0;
            usf_reg       <= '0;
            marker_reg    <= '0;
            mid_reg       <= 1'b0;
            emits_reg     <= 1'b0;
            full_reg      <= 1'b0;
            wf_reg        <= '0;
            mode_reg      <= '0;
            total_reg     <= '0;
            index_reg     <= '0;
        end else begin
            last_time_reg <= last_time_next;
            have_reg      <= have_next;
            usf_reg       <= usf_next;
            marker_reg    <= marker_next;
            mid_reg       <= mid_next;
            emits_reg     <= emits_next;
            full_reg      <= full_next;
            wf_reg        <= wf_next;
            mode_reg      <= mode_next;
            total_reg     <= total_next;
            index_reg     <= index_next;
        end
    end

endmodule

// ===== hdl/eurp_rect_clamp.sv =====
module eurp_rect_clamp import eurp_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    localparam int XW = $clog2(PANEL_WIDTH + 1),
    localparam int YW = $clog2(PANEL_HEIGHT + 1)
) (
    input  logic                      full,
    input  logic signed [COORD_W-1:0] in_left,
    input  logic signed [COORD_W-1:0] in_top,
    input  logic signed [COORD_W-1:0] in_right,
    input  logic signed [COORD_W-1:0] in_bottom,
    output logic [XW-1:0]             out_left,
    output logic [YW-1:0]             out_top,
    output logic [XW-1:0]             out_right,
    output logic [YW-1:0]             out_bottom
);

    localparam logic signed [COORD_W-1:0] PW_S = COORD_W'(PANEL_WIDTH);
    localparam logic signed [COORD_W-1:0] PH_S = COORD_W'(PANEL_HEIGHT);

    logic signed [COORD_W-1:0] l, t, r, b;

    always_comb begin
        l = (in_left   < 0)    ? '0   : in_left;
        t = (in_top    < 0)    ? '0   : in_top;
        r = (in_right  > PW_S) ? PW_S : in_right;
        b = (in_bottom > PH_S) ? PH_S : in_bottom;

        // A degenerate rectangle or a full commit covers the whole panel.
        if (full || r <= l || b <= t) begin
            out_left   = '0;
            out_top    = '0;
            out_right  = XW'(PANEL_WIDTH);
            out_bottom = YW'(PANEL_HEIGHT);
        end else begin
            out_left   = l[XW-1:0];
            out_top    = t[YW-1:0];
            out_right  = r[XW-1:0];
            out_bottom = b[YW-1:0];
        end
    end

endmodule

// ===== hdl/epaper_update_request_policy.sv =====
// Path: an accepted request passes through the input register, then the result register.
// Throughput: one request per cycle unless the result port stalls;
// the commit tracker decides each item in one pass.
// A stalled result holds in the result register while one more request waits upstream.
// Reset (aresetn low at a clock edge) empties both registers, clears the commit
// tracker and loads the register defaults.
module epaper_update_request_policy import eurp_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int MAX_RECTS    = DEF_MAX_RECTS,
    localparam int XW = $clog2(PANEL_WIDTH + 1),
    localparam int YW = $clog2(PANEL_HEIGHT + 1),
    localparam int RW = $clog2(MAX_RECTS + 1),
    localparam int M_BITS = 1 + 2 * XW + 2 * YW + WAVE_W + MODE_W + MARKER_W + FLAG_W + RW,
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // time_ms, test_only, frame_changed, full_request, rect_count,
    // in_left, in_top, in_right, in_bottom (lowest bits first), zero pad
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // emit, out_left, out_top, out_right, out_bottom, waveform, mode,
    // marker, flag_word, rect_total (lowest bits first), zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    in_item_t   in_item_reg, in_item_next;
    logic       in_valid_reg, in_valid_next;
    logic       m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;
    logic       s_accept;
    logic       advance;
    desc_info_t info;
    logic [RW-1:0] rect_total;
    logic [XW-1:0] rc_left, rc_right;
    logic [YW-1:0] rc_top, rc_bottom;

    eurp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    eurp_commit_ctrl #(
        .MAX_RECTS (MAX_RECTS)
    ) u_commit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item       (in_item_reg),
        .advance    (advance),
        .info       (info),
        .rect_total (rect_total)
    );

    eurp_rect_clamp #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_clamp (
        .full       (info.full),
        .in_left    (in_item_reg.left),
        .in_top     (in_item_reg.top),
        .in_right   (in_item_reg.right),
        .in_bottom  (in_item_reg.bottom),
        .out_left   (rc_left),
        .out_top    (rc_top),
        .out_right  (rc_right),
        .out_bottom (rc_bottom)
    );

    // The held request moves on whenever the result register is free or being drained.
    assign advance       = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_item_next = in_item_reg;
        if (s_accept) begin
            in_item_next.time_ms       = s_axis_tdata[31:0];
            in_item_next.test_only     = s_axis_tdata[32];
            in_item_next.frame_changed = s_axis_tdata[33];
            in_item_next.full_request  = s_axis_tdata[34];
            in_item_next.rect_count    = s_axis_tdata[38:35];
            in_item_next.left          = s_axis_tdata[54:39];
            in_item_next.top           = s_axis_tdata[70:55];
            in_item_next.right         = s_axis_tdata[86:71];
            in_item_next.bottom        = s_axis_tdata[102:87];
            in_item_next.last          = s_axis_tlast;
        end

        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        m_data_next = m_data_reg;
        m_last_next = m_last_reg;
        if (advance) begin
            // A result that carries no descriptor is all zeros.
            if (info.emit) begin
                m_data_next = M_TDATA_W'({rect_total, cfg.driver_flag_word, info.marker,
                                          info.mode, info.waveform, rc_bottom, rc_right,
                                          rc_top, rc_left, 1'b1});
                m_last_next = info.last;
            end else begin
                m_data_next = '0;
                m_last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== hdl/eurp_checker.sv =====
`include "epaper_update_request_policy_assert.svh"

module eurp_checker import eurp_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int MAX_RECTS    = DEF_MAX_RECTS,
    localparam int XW = $clog2(PANEL_WIDTH + 1),
    localparam int YW = $clog2(PANEL_HEIGHT + 1),
    localparam int RW = $clog2(MAX_RECTS + 1),
    localparam int M_BITS = 1 + 2 * XW + 2 * YW + WAVE_W + MODE_W + MARKER_W + FLAG_W + RW,
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    localparam int L_LO  = 1;
    localparam int T_LO  = L_LO + XW;
    localparam int R_LO  = T_LO + YW;
    localparam int B_LO  = R_LO + XW;
    localparam int RT_LO = B_LO + YW + WAVE_W + MODE_W + MARKER_W + FLAG_W;

    logic          emit;
    logic [XW-1:0] chk_left, chk_right;
    logic [YW-1:0] chk_top, chk_bottom;
    logic [RW-1:0] chk_total;

    assign emit       = m_axis_tdata[0];
    assign chk_left   = m_axis_tdata[L_LO +: XW];
    assign chk_top    = m_axis_tdata[T_LO +: YW];
    assign chk_right  = m_axis_tdata[R_LO +: XW];
    assign chk_bottom = m_axis_tdata[B_LO +: YW];
    assign chk_total  = m_axis_tdata[RT_LO +: RW];

    `EURP_ASSERT_IMPLY(a_silent_result_zero, m_axis_tvalid && !emit,
        m_axis_tdata == '0 && !m_axis_tlast)

    `EURP_ASSERT_IMPLY(a_descriptor_sane, m_axis_tvalid && emit,
        chk_left < chk_right && chk_top < chk_bottom
        && chk_right <= XW'(PANEL_WIDTH) && chk_bottom <= YW'(PANEL_HEIGHT)
        && chk_total != '0 && chk_total <= RW'(MAX_RECTS))

    `EURP_ASSERT_NEXT(a_stalled_result_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    `EURP_ASSERT_NEXT_ALWAYS(a_reset_empties_output, !aresetn, !m_axis_tvalid)

endmodule

bind epaper_update_request_policy eurp_checker #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .MAX_RECTS    (MAX_RECTS)
) u_eurp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
